[rtl/core/bdmg_pkg.sv]
// ============================================================================
// Bond-distance molecule grouper package
// Shared widths, payload and status types, and the bond-length lookup.
// ============================================================================
package bdmg_pkg;

   // Store size and the widths that follow from it.
   localparam int MAX_ATOMS = 256;
   localparam int ATOM_AW   = $clog2(MAX_ATOMS);
   localparam int COUNT_W   = ATOM_AW + 1;

   // Fixed field widths.
   localparam int ELEM_W   = 7;
   localparam int COORD_W  = 24;
   localparam int MOL_ID_W = 8;
   localparam int TOL_W    = 10;
   localparam int LEN_W    = 12;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * DIFF_W - 1;
   localparam int DIST_W   = SQ_W + 1;
   localparam int THR_SQ_W = 2 * LEN_W;

   // Configuration port.
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic CSR_IDX_TOLERANCE = 1'b0;

   // Request payload.
   typedef struct packed {
      logic                      start_set;
      logic [ELEM_W-1:0]         element;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [MOL_ID_W-1:0] molecule_id;
      logic                new_molecule;
      logic                store_full;
   } rsp_type;

   // One stored atom as it sits in the atom memory.
   typedef struct packed {
      logic [ELEM_W-1:0]         element;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [ATOM_AW-1:0]        molecule;
   } atom_entry_type;

   // Status of the bond compare pipeline toward the controller.
   typedef struct packed {
      logic               busy;
      logic               valid;
      logic               hit;
      logic [ATOM_AW-1:0] molecule;
   } pipe_status_type;

   // Bond length of an element pair in 1/1024 angstrom, or zero when the
   // pair is not listed. Lengths are the table values in hundredths of an
   // angstrom, scaled by 10.24 and rounded to nearest.
   function automatic logic [LEN_W-1:0] pair_length(input logic [ELEM_W-1:0] a,
                                                    input logic [ELEM_W-1:0] b);
      logic [ELEM_W-1:0] lo;
      logic [ELEM_W-1:0] hi;
      logic [LEN_W-1:0]  len;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case ({lo, hi})
         {7'd1, 7'd1}:   len = 12'd758;
         {7'd1, 7'd5}:   len = 12'd1219;
         {7'd1, 7'd6}:   len = 12'd1116;
         {7'd1, 7'd14}:  len = 12'd1516;
         {7'd1, 7'd32}:  len = 12'd1567;
         {7'd1, 7'd50}:  len = 12'd1741;
         {7'd1, 7'd7}:   len = 12'd1034;
         {7'd1, 7'd15}:  len = 12'd1475;
         {7'd1, 7'd33}:  len = 12'd1556;
         {7'd1, 7'd8}:   len = 12'd983;
         {7'd1, 7'd16}:  len = 12'd1372;
         {7'd1, 7'd34}:  len = 12'd1495;
         {7'd1, 7'd52}:  len = 12'd1741;
         {7'd1, 7'd9}:   len = 12'd942;
         {7'd1, 7'd17}:  len = 12'd1300;
         {7'd1, 7'd35}:  len = 12'd1444;
         {7'd1, 7'd53}:  len = 12'd1649;
         {7'd5, 7'd17}:  len = 12'd1792;
         {7'd6, 7'd6}:   len = 12'd1577;
         {7'd6, 7'd14}:  len = 12'd1894;
         {7'd6, 7'd32}:  len = 12'd1997;
         {7'd6, 7'd50}:  len = 12'd2212;
         {7'd6, 7'd82}:  len = 12'd2355;
         {7'd6, 7'd7}:   len = 12'd1505;
         {7'd6, 7'd15}:  len = 12'd1884;
         {7'd6, 7'd8}:   len = 12'd1464;
         {7'd6, 7'd16}:  len = 12'd1864;
         {7'd6, 7'd9}:   len = 12'd1382;
         {7'd6, 7'd17}:  len = 12'd1812;
         {7'd6, 7'd35}:  len = 12'd1987;
         {7'd6, 7'd53}:  len = 12'd2191;
         {7'd7, 7'd7}:   len = 12'd1485;
         {7'd7, 7'd8}:   len = 12'd1434;
         {7'd7, 7'd9}:   len = 12'd1393;
         {7'd7, 7'd17}:  len = 12'd1792;
         {7'd15, 7'd15}: len = 12'd2263;
         {7'd8, 7'd15}:  len = 12'd1669;
         {7'd15, 7'd16}: len = 12'd1905;
         {7'd9, 7'd15}:  len = 12'd1577;
         {7'd15, 7'd17}: len = 12'd2079;
         {7'd33, 7'd33}: len = 12'd2488;
         {7'd8, 7'd33}:  len = 12'd1823;
         {7'd9, 7'd33}:  len = 12'd1751;
         {7'd17, 7'd33}: len = 12'd2212;
         {7'd33, 7'd35}: len = 12'd2386;
         {7'd33, 7'd53}: len = 12'd2601;
         {7'd17, 7'd51}: len = 12'd2376;
         {7'd8, 7'd8}:   len = 12'd1516;
         {7'd8, 7'd9}:   len = 12'd1454;
         {7'd8, 7'd16}:  len = 12'd1464;
         {7'd16, 7'd16}: len = 12'd1526;
         {7'd9, 7'd16}:  len = 12'd1597;
         {7'd16, 7'd17}: len = 12'd2120;
         {7'd34, 7'd34}: len = 12'd2202;
         {7'd9, 7'd9}:   len = 12'd1454;
         {7'd17, 7'd17}: len = 12'd2038;
         {7'd35, 7'd35}: len = 12'd2335;
         {7'd53, 7'd53}: len = 12'd2734;
         {7'd9, 7'd53}:  len = 12'd1956;
         {7'd17, 7'd53}: len = 12'd2376;
         {7'd9, 7'd36}:  len = 12'd1946;
         {7'd8, 7'd54}:  len = 12'd1792;
         {7'd9, 7'd54}:  len = 12'd1997;
         {7'd14, 7'd14}: len = 12'd2386;
         {7'd8, 7'd14}:  len = 12'd1669;
         {7'd14, 7'd16}: len = 12'd2048;
         {7'd9, 7'd14}:  len = 12'd1638;
         {7'd14, 7'd17}: len = 12'd2068;
         {7'd14, 7'd35}: len = 12'd2202;
         {7'd14, 7'd53}: len = 12'd2488;
         {7'd32, 7'd32}: len = 12'd2468;
         {7'd9, 7'd32}:  len = 12'd1720;
         {7'd17, 7'd32}: len = 12'd2150;
         {7'd32, 7'd35}: len = 12'd2355;
         {7'd17, 7'd50}: len = 12'd2386;
         {7'd35, 7'd50}: len = 12'd2560;
         {7'd50, 7'd53}: len = 12'd2765;
         {7'd17, 7'd82}: len = 12'd2478;
         {7'd53, 7'd82}: len = 12'd2857;
         default:        len = '0;
      endcase
      return len;
   endfunction

endpackage

[rtl/core/bdmg_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module bdmg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bdmg_bond_pipe.sv]
// ============================================================================
// Bond compare pipeline
// Compares the incoming atom with one stored atom per cycle: bond length
// lookup and coordinate differences, squares, then sum and threshold test.
// ============================================================================
module bdmg_bond_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  bdmg_pkg::atom_entry_type            entry,
   input  logic [bdmg_pkg::ELEM_W-1:0]         new_element,
   input  logic signed [bdmg_pkg::COORD_W-1:0] new_x,
   input  logic signed [bdmg_pkg::COORD_W-1:0] new_y,
   input  logic signed [bdmg_pkg::COORD_W-1:0] new_z,
   input  logic [bdmg_pkg::TOL_W-1:0]          tolerance,
   output bdmg_pkg::pipe_status_type           status
);

   // Stage 1: differences and threshold.
   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_listed_ff, s1_listed_in;
   logic signed [bdmg_pkg::DIFF_W-1:0] s1_dx_ff, s1_dx_in;
   logic signed [bdmg_pkg::DIFF_W-1:0] s1_dy_ff, s1_dy_in;
   logic signed [bdmg_pkg::DIFF_W-1:0] s1_dz_ff, s1_dz_in;
   logic [bdmg_pkg::LEN_W-1:0]         s1_thr_ff, s1_thr_in;
   logic [bdmg_pkg::ATOM_AW-1:0]       s1_mol_ff, s1_mol_in;
   logic [bdmg_pkg::LEN_W-1:0]         len;

   // Stage 2: squares.
   logic                                 s2_valid_ff, s2_valid_in;
   logic                                 s2_listed_ff, s2_listed_in;
   logic [bdmg_pkg::SQ_W-1:0]            s2_sqx_ff, s2_sqx_in;
   logic [bdmg_pkg::SQ_W-1:0]            s2_sqy_ff, s2_sqy_in;
   logic [bdmg_pkg::SQ_W-1:0]            s2_sqz_ff, s2_sqz_in;
   logic [bdmg_pkg::THR_SQ_W-1:0]        s2_thr_sq_ff, s2_thr_sq_in;
   logic [bdmg_pkg::ATOM_AW-1:0]         s2_mol_ff, s2_mol_in;
   logic signed [2*bdmg_pkg::DIFF_W-1:0] prod_x, prod_y, prod_z;

   // Stage 3: distance test.
   logic                         s3_valid_ff, s3_valid_in;
   logic                         s3_hit_ff, s3_hit_in;
   logic [bdmg_pkg::ATOM_AW-1:0] s3_mol_ff, s3_mol_in;
   logic [bdmg_pkg::DIST_W-1:0]  dist_sq;

   // Stage 1 logic: unlisted pairs give a zero length and never bond.
   always_comb begin
      len          = bdmg_pkg::pair_length(new_element, entry.element);
      s1_valid_in  = in_valid;
      s1_listed_in = (len != '0);
      s1_thr_in    = len + bdmg_pkg::LEN_W'(tolerance);
      s1_dx_in     = {new_x[bdmg_pkg::COORD_W-1], new_x}
                   - {entry.pos_x[bdmg_pkg::COORD_W-1], entry.pos_x};
      s1_dy_in     = {new_y[bdmg_pkg::COORD_W-1], new_y}
                   - {entry.pos_y[bdmg_pkg::COORD_W-1], entry.pos_y};
      s1_dz_in     = {new_z[bdmg_pkg::COORD_W-1], new_z}
                   - {entry.pos_z[bdmg_pkg::COORD_W-1], entry.pos_z};
      s1_mol_in    = entry.molecule;
   end

   // Stage 2 logic: squares are never negative, so the sign bit is dropped.
   always_comb begin
      prod_x       = s1_dx_ff * s1_dx_ff;
      prod_y       = s1_dy_ff * s1_dy_ff;
      prod_z       = s1_dz_ff * s1_dz_ff;
      s2_valid_in  = s1_valid_ff;
      s2_listed_in = s1_listed_ff;
      s2_sqx_in    = prod_x[bdmg_pkg::SQ_W-1:0];
      s2_sqy_in    = prod_y[bdmg_pkg::SQ_W-1:0];
      s2_sqz_in    = prod_z[bdmg_pkg::SQ_W-1:0];
      s2_thr_sq_in = s1_thr_ff * s1_thr_ff;
      s2_mol_in    = s1_mol_ff;
   end

   // Stage 3 logic: inclusive compare of squared distance and threshold.
   always_comb begin
      dist_sq     = bdmg_pkg::DIST_W'(s2_sqx_ff) + bdmg_pkg::DIST_W'(s2_sqy_ff)
                  + bdmg_pkg::DIST_W'(s2_sqz_ff);
      s3_valid_in = s2_valid_ff;
      s3_hit_in   = s2_listed_ff && (dist_sq <= bdmg_pkg::DIST_W'(s2_thr_sq_ff));
      s3_mol_in   = s2_mol_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      s1_listed_ff <= s1_listed_in;
      s1_dx_ff     <= s1_dx_in;
      s1_dy_ff     <= s1_dy_in;
      s1_dz_ff     <= s1_dz_in;
      s1_thr_ff    <= s1_thr_in;
      s1_mol_ff    <= s1_mol_in;
      s2_listed_ff <= s2_listed_in;
      s2_sqx_ff    <= s2_sqx_in;
      s2_sqy_ff    <= s2_sqy_in;
      s2_sqz_ff    <= s2_sqz_in;
      s2_thr_sq_ff <= s2_thr_sq_in;
      s2_mol_ff    <= s2_mol_in;
      s3_hit_ff    <= s3_hit_in;
      s3_mol_ff    <= s3_mol_in;
   end

   assign status.busy     = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign status.valid    = s3_valid_ff;
   assign status.hit      = s3_hit_ff;
   assign status.molecule = s3_mol_ff;

endmodule

[rtl/core/bond_distance_molecule_grouper.sv]
// ============================================================================
// Bond-distance molecule grouper
// Places each incoming atom in the lowest-numbered molecule that holds an
// atom it bonds with, or opens a new molecule, and stores the atom unless the store is full.
// ============================================================================
// A request is answered once the scan has read each stored atom, the compare
// pipeline has drained and the atom is placed; an empty or full store skips
// the scan. No new request is taken until the last one is answered; the scan
// reads one stored atom per cycle through the atom memory's single read port.
// Reset clears the atom and molecule counts and the tolerance register. The
// atom memory is not cleared: only entries below the atom count are read.
module bond_distance_molecule_grouper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  bdmg_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output bdmg_pkg::rsp_type               rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bdmg_pkg::PADDR_W-1:0]    paddr,
   input  logic [bdmg_pkg::PDATA_W-1:0]    pwdata,
   output logic [bdmg_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   bdmg_pkg::req_type               item_ff, item_in;
   logic [bdmg_pkg::COUNT_W-1:0]    atom_count_ff, atom_count_in;
   logic [bdmg_pkg::COUNT_W-1:0]    mol_count_ff, mol_count_in;
   logic [bdmg_pkg::COUNT_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                            read_valid_ff, read_valid_in;
   logic                            found_ff, found_in;
   logic [bdmg_pkg::ATOM_AW-1:0]    best_ff, best_in;
   logic                            full_ff, full_in;
   logic [bdmg_pkg::TOL_W-1:0]      tolerance_ff, tolerance_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bdmg_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            req_accept;
   logic                            out_free;
   logic                            csr_write;
   logic [bdmg_pkg::COUNT_W-1:0]    count_start;
   logic [bdmg_pkg::COUNT_W-1:0]    scan_next;
   logic [bdmg_pkg::ATOM_AW-1:0]    placed_mol;
   logic                            ram_we;
   bdmg_pkg::atom_entry_type        ram_wdata;
   bdmg_pkg::atom_entry_type        ram_rdata;
   logic [$bits(bdmg_pkg::atom_entry_type)-1:0] ram_rd_bits;
   bdmg_pkg::pipe_status_type       pipe_status;

   // Configuration port: always ready, one tolerance register.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr[2] == bdmg_pkg::CSR_IDX_TOLERANCE)
                    ? bdmg_pkg::PDATA_W'(tolerance_ff) : '0;

   always_comb begin
      tolerance_in = tolerance_ff;
      if (csr_write && (paddr[2] == bdmg_pkg::CSR_IDX_TOLERANCE)) begin
         tolerance_in = pwdata[bdmg_pkg::TOL_W-1:0];
      end
   end

   // Handshake helpers.
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid & req_ready;
   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign count_start = req_payload.start_set ? '0 : atom_count_ff;
   assign scan_next   = scan_addr_ff + bdmg_pkg::COUNT_W'(1);
   assign placed_mol  = found_ff ? best_ff : mol_count_ff[bdmg_pkg::ATOM_AW-1:0];

   // Atom memory: reads only during the scan and one write at the end of a
   // request, so the two never touch the same entry in the same window.
   assign ram_we             = (state_ff == ST_FINISH) && out_free && !full_ff;
   assign ram_wdata.element  = item_ff.element;
   assign ram_wdata.pos_x    = item_ff.pos_x;
   assign ram_wdata.pos_y    = item_ff.pos_y;
   assign ram_wdata.pos_z    = item_ff.pos_z;
   assign ram_wdata.molecule = placed_mol;
   assign ram_rdata          = bdmg_pkg::atom_entry_type'(ram_rd_bits);

   bdmg_ram #(
      .WIDTH($bits(bdmg_pkg::atom_entry_type)),
      .DEPTH(bdmg_pkg::MAX_ATOMS)
   ) u_atom_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(atom_count_ff[bdmg_pkg::ATOM_AW-1:0]),
      .wr_data(ram_wdata),
      .rd_addr(scan_addr_ff[bdmg_pkg::ATOM_AW-1:0]),
      .rd_data(ram_rd_bits)
   );

   bdmg_bond_pipe u_bond_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (read_valid_ff),
      .entry      (ram_rdata),
      .new_element(item_ff.element),
      .new_x      (item_ff.pos_x),
      .new_y      (item_ff.pos_y),
      .new_z      (item_ff.pos_z),
      .tolerance  (tolerance_ff),
      .status     (pipe_status)
   );

   // Controller: accept, scan the store, drain the pipeline, place the atom.
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      atom_count_in = atom_count_ff;
      mol_count_in  = mol_count_ff;
      scan_addr_in  = scan_addr_ff;
      read_valid_in = 1'b0;
      found_in      = found_ff;
      best_in       = best_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_in        = rsp_ff;

      // Keep the lowest molecule among bonded atoms.
      if (pipe_status.valid && pipe_status.hit &&
          (!found_ff || (pipe_status.molecule < best_ff))) begin
         found_in = 1'b1;
         best_in  = pipe_status.molecule;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in       = req_payload;
               atom_count_in = count_start;
               mol_count_in  = req_payload.start_set ? '0 : mol_count_ff;
               scan_addr_in  = '0;
               found_in      = 1'b0;
               full_in       = (count_start == bdmg_pkg::COUNT_W'(bdmg_pkg::MAX_ATOMS));
               if ((count_start == bdmg_pkg::COUNT_W'(bdmg_pkg::MAX_ATOMS)) ||
                   (count_start == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            read_valid_in = 1'b1;
            scan_addr_in  = scan_next;
            if (scan_next == atom_count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!read_valid_ff && !pipe_status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (full_ff) begin
                  rsp_in.molecule_id  = '0;
                  rsp_in.new_molecule = 1'b0;
                  rsp_in.store_full   = 1'b1;
               end else begin
                  rsp_in.molecule_id  = bdmg_pkg::MOL_ID_W'(placed_mol);
                  rsp_in.new_molecule = ~found_ff;
                  rsp_in.store_full   = 1'b0;
                  atom_count_in       = atom_count_ff + bdmg_pkg::COUNT_W'(1);
                  if (!found_ff) begin
                     mol_count_in = mol_count_ff + bdmg_pkg::COUNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         atom_count_ff <= '0;
         mol_count_ff  <= '0;
         read_valid_ff <= 1'b0;
         tolerance_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         atom_count_ff <= atom_count_in;
         mol_count_ff  <= mol_count_in;
         read_valid_ff <= read_valid_in;
         tolerance_ff  <= tolerance_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      scan_addr_ff <= scan_addr_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      full_ff      <= full_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Every molecule holds at least one atom.
   assert property (@(posedge clock) disable iff (reset)
      mol_count_ff <= atom_count_ff)
      else $error("molecule count exceeds atom count");

   // The scan never reads past the stored atoms.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_addr_ff < atom_count_ff))
      else $error("scan address beyond stored atoms");

   // Compare results arrive only while a request is being scanned.
   assert property (@(posedge clock) disable iff (reset)
      pipe_status.valid |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("compare result outside a scan");

   // An atom is never written into a full store.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (atom_count_ff < bdmg_pkg::COUNT_W'(bdmg_pkg::MAX_ATOMS)))
      else $error("atom written into a full store");

endmodule
